// ===== sv/wmm_pkg.sv =====
package wmm_pkg;

    // Default geometry of the sample window.
    localparam int WINDOW_DEF      = 80;
    localparam int SAMPLE_BITS_DEF = 16;

    // Configuration register widths and reset values.
    localparam int SPAN_CFG_W    = 16;
    localparam int PCT_W         = 7;
    localparam int SPAN_RESET    = 20;
    localparam int PERCENT_RESET = 10;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_PCT = 1'b1;

    // Margin is a percentage: the product is divided by this constant.
    localparam int PERCENT_DIV = 100;

    // Width of the reported bounds.
    localparam int OUT_BITS = 18;

endpackage

// ===== sv/window_min_max_autoscale_unit.sv =====
// Sliding-window minimum/maximum with a widened display range.
// Input channel: one signed sample per beat (i_sample_valid / o_sample_ready).
// Output channel: one result per input beat (o_res_valid / i_res_ready)
// carrying o_range_valid, o_range_low and o_range_high.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 = minimum span, 1 = margin percent); write only while the block is idle.
// Each sample is written into a ring memory, then every held entry is read
// back through the single read port, one per cycle, to find the minimum and
// maximum. The margin is span times percent, divided by 100 with a shift and
// a reciprocal multiply. A result passes through the read-back of the held
// samples (up to WINDOW), the span, the product, the division and the output
// register. With fewer than two samples held the sequencer goes straight
// from the write to the output step. One sample is in work at a time; the
// next is taken in the cycle after the result is loaded, even while the
// receiver stalls it there.
// Reset clears the sample count, the write slot and the output valid flag; the
// ring itself is not cleared since only written entries are read.
module window_min_max_autoscale_unit import wmm_pkg::*; #(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_sample_valid,
    output logic                          o_sample_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic                          o_range_valid,
    output logic signed [OUT_BITS-1:0]    o_range_low,
    output logic signed [OUT_BITS-1:0]    o_range_high
);

    localparam int ADDR_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SPAN_W = (SAMPLE_BITS > SPAN_CFG_W) ? SAMPLE_BITS : SPAN_CFG_W;
    localparam int PROD_W = SPAN_W + PCT_W;
    localparam int BW     = ((SAMPLE_BITS > PROD_W) ? SAMPLE_BITS : PROD_W) + 2;

    localparam logic signed [BW-1:0] L_OUT_MAX = BW'(2 ** (OUT_BITS - 1) - 1);
    localparam logic signed [BW-1:0] L_OUT_MIN = BW'(-(2 ** (OUT_BITS - 1)));

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_SPAN = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]                    r_state, n_state;
    logic [ADDR_W-1:0]             r_wslot;
    logic [CNT_W-1:0]              r_held;
    logic [CNT_W-1:0]              r_idx;
    logic                          r_rd_pend;
    logic                          r_first;
    logic                          r_ok;
    logic signed [SAMPLE_BITS-1:0] r_min;
    logic signed [SAMPLE_BITS-1:0] r_max;
    logic [SPAN_W-1:0]             r_span;
    logic [SPAN_CFG_W-1:0]         r_min_span;
    logic [PCT_W-1:0]              r_pct;
    logic                          r_res_valid;
    logic                          r_range_valid;
    logic signed [OUT_BITS-1:0]    r_range_low;
    logic signed [OUT_BITS-1:0]    r_range_high;

    logic                          accept;
    logic                          rd_en;
    logic                          out_free;
    logic [CNT_W-1:0]              n_held;
    logic [ADDR_W-1:0]             n_wslot;
    logic [SAMPLE_BITS-1:0]        ram_rd;
    logic signed [SAMPLE_BITS-1:0] rd_sample;
    logic [SPAN_W-1:0]             diff;
    logic                          div_start;
    logic                          div_done;
    logic [PROD_W-1:0]             dividend;
    logic [PROD_W-1:0]             quot;
    logic signed [BW-1:0]          low_w;
    logic signed [BW-1:0]          high_w;
    logic signed [BW-1:0]          low_c;
    logic signed [BW-1:0]          high_c;

    // Handshake and bookkeeping for the ring.
    always_comb begin
        accept   = i_sample_valid && (r_state == S_IDLE);
        rd_en    = (r_state == S_SCAN) && (r_idx < r_held);
        out_free = !r_res_valid || i_res_ready;
        n_held   = (r_held < CNT_W'(WINDOW)) ? r_held + 1'b1 : r_held;
        n_wslot  = (r_wslot == ADDR_W'(WINDOW - 1)) ? '0 : r_wslot + 1'b1;
    end

    assign o_sample_ready = (r_state == S_IDLE);

    // Sequencer: write, scan, span, multiply, divide, output; or write, output.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (n_held < CNT_W'(2)) ? S_OUT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (!rd_en && !r_rd_pend) begin
                    n_state = S_SPAN;
                end
            end
            S_SPAN:  n_state = S_MUL;
            S_MUL:   n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wslot   <= '0;
            r_held    <= '0;
            r_idx     <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= rd_en;
            if (accept) begin
                r_wslot <= n_wslot;
                r_held  <= n_held;
                r_idx   <= '0;
            end else if (rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_span <= SPAN_CFG_W'(SPAN_RESET);
            r_pct      <= PCT_W'(PERCENT_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_SPAN:   r_min_span <= i_cfg_data[SPAN_CFG_W-1:0];
                CFG_MARGIN_PCT: r_pct      <= i_cfg_data[PCT_W-1:0];
                default:        r_pct      <= r_pct;
            endcase
        end
    end

    // Sample ring.
    wmm_ring #(
        .DEPTH  (WINDOW),
        .DATA_W (SAMPLE_BITS),
        .ADDR_W (ADDR_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (r_wslot),
        .i_wr_data (i_sample),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[ADDR_W-1:0]),
        .o_rd_data (ram_rd)
    );

    assign rd_sample = signed'(ram_rd);

    // Running minimum and maximum over the read-back entries.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_first <= 1'b1;
            r_ok    <= (n_held >= CNT_W'(2));
        end else if (r_rd_pend) begin
            r_first <= 1'b0;
            if (r_first || (rd_sample < r_min)) begin
                r_min <= rd_sample;
            end
            if (r_first || (rd_sample > r_max)) begin
                r_max <= rd_sample;
            end
        end
    end

    // Span, forced up to the configured minimum span.
    assign diff = SPAN_W'(unsigned'(r_max - r_min));

    always_ff @(posedge i_clk) begin
        if (r_state == S_SPAN) begin
            r_span <= (diff < SPAN_W'(r_min_span)) ? SPAN_W'(r_min_span) : diff;
        end
    end

    // The product is registered inside the divider as it starts.
    assign div_start = (r_state == S_MUL);
    assign dividend  = PROD_W'(r_span) * PROD_W'(r_pct);

    wmm_div #(
        .DIVIDEND_W (PROD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    // Widened bounds, saturated to the output width.
    always_comb begin
        low_w  = BW'(r_min) - $signed(BW'(quot));
        high_w = BW'(r_max) + $signed(BW'(quot));
        low_c  = (low_w > L_OUT_MAX) ? L_OUT_MAX :
                 (low_w < L_OUT_MIN) ? L_OUT_MIN : low_w;
        high_c = (high_w > L_OUT_MAX) ? L_OUT_MAX :
                 (high_w < L_OUT_MIN) ? L_OUT_MIN : high_w;
    end

    // Output register; it holds its beat while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_range_valid <= r_ok;
            r_range_low   <= r_ok ? low_c[OUT_BITS-1:0] : '0;
            r_range_high  <= r_ok ? high_c[OUT_BITS-1:0] : '0;
        end
    end

    assign o_res_valid   = r_res_valid;
    assign o_range_valid = r_range_valid;
    assign o_range_low   = r_range_low;
    assign o_range_high  = r_range_high;

    // The fill count saturates at the window and the write slot wraps inside it.
    a_ring_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held <= CNT_W'(WINDOW)) && (r_wslot <= ADDR_W'(WINDOW - 1)))
        else $error("ring count or write slot out of range");

    // A valid range never has its low bound above its high bound.
    a_bounds_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_range_valid) |-> (o_range_low <= o_range_high))
        else $error("range low bound above high bound");

    // The divider only finishes while the sequencer waits for it.
    a_div_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its step");

endmodule

// ===== sv/wmm_ring.sv =====
module wmm_ring import wmm_pkg::*; #(
    parameter int DEPTH  = WINDOW_DEF,
    parameter int DATA_W = SAMPLE_BITS_DEF,
    parameter int ADDR_W = $clog2(WINDOW_DEF)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Single write port, single read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/wmm_div.sv =====
module wmm_div import wmm_pkg::*; #(
    parameter int DIVIDEND_W = SPAN_CFG_W + PCT_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    // Division by 100 is a shift by two followed by division by 25. The odd
    // part uses a reciprocal rounded up with SH fraction bits; with 2**5 >= 25
    // the result is exact for every shifted dividend of X_W bits, and since 25
    // is above 16 the reciprocal fits in SH - 4 bits.
    localparam int QUARTER = PERCENT_DIV / 4;
    localparam int X_W     = DIVIDEND_W - 2;
    localparam int SH      = X_W + 5;
    localparam int M_W     = SH - 4;
    localparam int P_W     = X_W + M_W;
    localparam logic [63:0]    L_RECIP_W = ((64'd1 << SH) + 64'(QUARTER - 1)) / 64'(QUARTER);
    localparam logic [M_W-1:0] L_RECIP   = M_W'(L_RECIP_W);

    logic                  r_busy;
    logic                  r_done;
    logic [X_W-1:0]        r_x;
    logic [DIVIDEND_W-1:0] r_q;

    logic [P_W-1:0]        prod;

    // Reciprocal product of the shifted dividend.
    assign prod = P_W'(r_x) * P_W'(L_RECIP);

    // Control: a start loads the dividend, the next cycle forms the quotient.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: drop the factor of four, then keep the integer part of the product.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_dividend[DIVIDEND_W-1:2];
        end
        if (r_busy) begin
            r_q <= DIVIDEND_W'(prod[P_W-1:SH]);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

    // A new division only starts once the previous one has finished.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

endmodule
